/* rtl/core/mm_pkg.sv */
// shared types, constants and helpers of the matrix multiply block
// no dependencies
package mm_pkg;

	localparam int MAX_DIM   = 8;
	localparam int ELEM_BITS = 16;
	localparam int IDX_W     = $clog2(MAX_DIM);
	localparam int ADDR_W    = 2 * IDX_W;
	localparam int DIM_W     = 4;
	localparam int PROD_W    = 2 * ELEM_BITS;
	localparam int SUM_W     = 36;

	localparam logic [1:0] CMD_WRITE_A = 2'd0;
	localparam logic [1:0] CMD_WRITE_B = 2'd1;
	localparam logic [1:0] CMD_COMPUTE = 2'd2;

	localparam logic [1:0] REG_A_ROWS    = 2'd0;
	localparam logic [1:0] REG_INNER_LEN = 2'd1;
	localparam logic [1:0] REG_B_COLS    = 2'd2;

	// control travelling alongside the operands into the mac
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} mac_ctl_t;

	// highest usable index for a configured dimension (0 acts as 1, large values clip)
	function automatic logic [IDX_W-1:0] dim_last(input logic [DIM_W-1:0] d);
		logic [IDX_W-1:0] r;
		if (d == '0) begin
			r = '0;
		end else if (d > DIM_W'(MAX_DIM)) begin
			r = IDX_W'(MAX_DIM - 1);
		end else begin
			r = IDX_W'(d - 1'b1);
		end
		return r;
	endfunction

endpackage

/* rtl/core/mm_mac.sv */
// shared multiply-accumulate unit: registered product, then 36-bit accumulator
// depends on mm_pkg
module mm_mac
	import mm_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic signed [ELEM_BITS-1:0] a_data,
	input  logic signed [ELEM_BITS-1:0] b_data,
	input  mac_ctl_t                    ctl,
	output logic signed [SUM_W-1:0]     acc,
	output logic                        done
);

	logic signed [PROD_W-1:0] product_s2;
	mac_ctl_t                 ctl_s2;
	logic signed [SUM_W-1:0]  acc_q;
	logic                     done_q;
	logic signed [SUM_W-1:0]  prod_ext;

	assign prod_ext = SUM_W'(product_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s2 <= ctl;
			done_q <= ctl_s2.valid && ctl_s2.last;
		end
	end

	always_ff @(posedge clk) begin
		product_s2 <= a_data * b_data;
		if (ctl_s2.valid) begin
			// first term restarts the sum, wraps modulo 2^36
			acc_q <= ctl_s2.first ? prod_ext : acc_q + prod_ext;
		end
	end

	assign acc  = acc_q;
	assign done = done_q;

endmodule

/* rtl/core/matrix_multiply_top.sv */
// matrix multiply block top level: stores, sequencer, config registers, stream ports
// depends on mm_pkg and mm_mac
//
// computes C = A x B from two 8x8 element stores. a load word (tuser 0 or 1) writes one
// signed Q4.12 element of A or B at row/col. a compute word (tuser 2) emits every
// element of C in row-major order as a signed Q12.24 36-bit exact sum, with tlast on
// the final element; tuser 3 is accepted and ignored. the dimensions come from the
// a_rows, inner_len and b_cols registers (0 acts as 1, above 8 acts as 8). one shared
// multiply-accumulate unit does all the work, one product per cycle while the sequencer
// is in its run state; each output element goes through operand read, multiply,
// accumulate and hand over to the output register, and the hand over waits while the
// output side stalls. s_tready is low while a compute is running. elements never
// written before a compute read as undefined. the stores have no reset and need no
// clearing pass.
module matrix_multiply_top
	import mm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // row[2:0], col[5:3], value[21:6], zero pad
	input  logic [1:0]  s_tuser,   // command[1:0]
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // out_row[2:0], out_col[5:3], sum[41:6], zero pad
	output logic        m_tlast,
	// config port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;  // takes words
	localparam logic [1:0] ST_RUN  = 2'd1;  // issuing one operand pair per cycle
	localparam logic [1:0] ST_WAIT = 2'd2;  // mac pipeline draining
	localparam logic [1:0] ST_EMIT = 2'd3;  // handing the sum to the output register

	// config registers
	logic [DIM_W-1:0] a_rows_q, inner_len_q, b_cols_q;
	logic             cfg_wr;
	logic [1:0]       cfg_idx;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_rows_q    <= DIM_W'(8);
			inner_len_q <= DIM_W'(8);
			b_cols_q    <= DIM_W'(8);
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_A_ROWS:    a_rows_q    <= pwdata[DIM_W-1:0];
				REG_INNER_LEN: inner_len_q <= pwdata[DIM_W-1:0];
				REG_B_COLS:    b_cols_q    <= pwdata[DIM_W-1:0];
				default: ;     // writes beyond the register list are dropped
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_A_ROWS:    prdata = 32'(a_rows_q);
			REG_INNER_LEN: prdata = 32'(inner_len_q);
			REG_B_COLS:    prdata = 32'(b_cols_q);
			default:       prdata = '0;
		endcase
	end

	// clipped dimensions as highest index
	logic [IDX_W-1:0] nr_last, nk_last, nc_last;
	assign nr_last = dim_last(a_rows_q);
	assign nk_last = dim_last(inner_len_q);
	assign nc_last = dim_last(b_cols_q);

	// input word fields
	logic [1:0]                  in_cmd;
	logic [IDX_W-1:0]            in_row, in_col;
	logic signed [ELEM_BITS-1:0] in_value;
	logic                        in_acc;

	assign in_cmd   = s_tuser;
	assign in_row   = s_tdata[2:0];
	assign in_col   = s_tdata[5:3];
	assign in_value = s_tdata[21:6];

	logic [1:0]       state_q;
	logic [IDX_W-1:0] i_q, j_q, k_q;
	logic             m_valid_q;
	logic             out_free, out_load;
	logic             mac_done;
	logic signed [SUM_W-1:0] mac_acc;

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign out_load = (state_q == ST_EMIT) && out_free;

	// element stores, one write port (loads) and one registered read port (compute)
	logic signed [ELEM_BITS-1:0] store_a_q [MAX_DIM*MAX_DIM];
	logic signed [ELEM_BITS-1:0] store_b_q [MAX_DIM*MAX_DIM];
	logic signed [ELEM_BITS-1:0] rd_a_s1, rd_b_s1;
	mac_ctl_t                    issue_ctl, ctl_s1;

	always_ff @(posedge clk) begin
		if (in_acc && in_cmd == CMD_WRITE_A) begin
			store_a_q[{in_row, in_col}] <= in_value;
		end
		if (in_acc && in_cmd == CMD_WRITE_B) begin
			store_b_q[{in_row, in_col}] <= in_value;
		end
		rd_a_s1 <= store_a_q[{i_q, k_q}];
		rd_b_s1 <= store_b_q[{k_q, j_q}];
	end

	// one operand pair per run cycle, tagged with the start and end of its dot product
	always_comb begin
		issue_ctl.valid = (state_q == ST_RUN);
		issue_ctl.first = (k_q == '0);
		issue_ctl.last  = (k_q == nk_last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= issue_ctl;
		end
	end

	mm_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.a_data (rd_a_s1),
		.b_data (rd_b_s1),
		.ctl    (ctl_s1),
		.acc    (mac_acc),
		.done   (mac_done)
	);

	// sequencer over rows i, columns j and inner index k
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			i_q       <= '0;
			j_q       <= '0;
			k_q       <= '0;
			m_valid_q <= 1'b0;
		end else begin
			// a new word loads, an unaccepted one stays
			m_valid_q <= out_load || (m_valid_q && !m_tready);
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && in_cmd == CMD_COMPUTE) begin
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (k_q == nk_last) begin
						k_q     <= '0;
						state_q <= ST_WAIT;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_WAIT: begin
					if (mac_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (j_q == nc_last) begin
							j_q <= '0;
							if (i_q == nr_last) begin
								state_q <= ST_IDLE;
							end else begin
								i_q     <= i_q + 1'b1;
								state_q <= ST_RUN;
							end
						end else begin
							j_q     <= j_q + 1'b1;
							state_q <= ST_RUN;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output word register
	logic [IDX_W-1:0]        out_row_q, out_col_q;
	logic signed [SUM_W-1:0] out_sum_q;
	logic                    out_last_q;

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_row_q  <= i_q;
			out_col_q  <= j_q;
			out_sum_q  <= mac_acc;
			out_last_q <= (i_q == nr_last) && (j_q == nc_last);
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'd0, out_sum_q, out_col_q, out_row_q};
	assign m_tlast  = out_last_q;

	// checks
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> state_q == ST_WAIT)
		else $error("mac finished outside the drain state");

	a_k_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> k_q <= nk_last)
		else $error("inner index beyond configured length");

	a_read_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s1.valid |-> $past(state_q) == ST_RUN)
		else $error("operand read not issued by the run state");

endmodule
